### rtl/gr128_pkg.sv
// Grain-128AEAD core package: transaction payload types, item kinds,
// cipher clock modes and the command structs between sequencer and units.
// No dependencies.
package gr128_pkg;

    localparam logic [2:0] KIND_START    = 3'd0;
    localparam logic [2:0] KIND_AD       = 3'd1;
    localparam logic [2:0] KIND_ENCRYPT  = 3'd2;
    localparam logic [2:0] KIND_DECRYPT  = 3'd3;
    localparam logic [2:0] KIND_FINALIZE = 3'd4;
    localparam logic [2:0] KIND_CHECK    = 3'd5;

    localparam logic [1:0] CFG_KEY_LOW    = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH   = 2'd1;
    localparam logic [1:0] CFG_NONCE_LOW  = 2'd2;
    localparam logic [1:0] CFG_NONCE_HIGH = 2'd3;

    localparam logic [31:0] IV_PAD = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        MODE_RUN    = 2'd0,
        MODE_INIT   = 2'd1,
        MODE_KEYADD = 2'd2
    } t_mode;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_in;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       tag_fail;
    } t_out;

    typedef struct packed {
        logic  load;
        logic  step;
        t_mode mode;
        logic  kbit;
    } t_ciph_cmd;

    typedef struct packed {
        logic clear;
        logic acc_shift;
        logic sr_shift;
        logic add;
        logic fold;
        logic bit_in;
    } t_auth_cmd;

endpackage

### rtl/gr128_cipher.sv
// Grain-128AEAD cipher unit: 128-bit LFSR and NFSR, one cipher clock per cycle while step is set.
// Depends on gr128_pkg.
module gr128_cipher
    import gr128_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ciph_cmd     i_cmd,
    input  logic [127:0]  i_key,
    input  logic [95:0]   i_iv,
    output logic          o_y
);

    logic [127:0] r_lfsr, n_lfsr;
    logic [127:0] r_nfsr, n_nfsr;
    logic         lfb, nfb, hval, yval, lout, lin, nin;

    always_comb begin
        lfb = r_lfsr[96] ^ r_lfsr[81] ^ r_lfsr[70] ^ r_lfsr[38] ^ r_lfsr[7] ^ r_lfsr[0];
        nfb = r_nfsr[96] ^ r_nfsr[91] ^ r_nfsr[56] ^ r_nfsr[26] ^ r_nfsr[0]
            ^ (r_nfsr[84] & r_nfsr[68]) ^ (r_nfsr[67] & r_nfsr[3])
            ^ (r_nfsr[65] & r_nfsr[61]) ^ (r_nfsr[59] & r_nfsr[27])
            ^ (r_nfsr[48] & r_nfsr[40]) ^ (r_nfsr[18] & r_nfsr[17])
            ^ (r_nfsr[13] & r_nfsr[11])
            ^ (r_nfsr[82] & r_nfsr[78] & r_nfsr[70])
            ^ (r_nfsr[25] & r_nfsr[24] & r_nfsr[22])
            ^ (r_nfsr[95] & r_nfsr[93] & r_nfsr[92] & r_nfsr[88]);
        hval = (r_nfsr[12] & r_lfsr[8]) ^ (r_lfsr[13] & r_lfsr[20])
             ^ (r_nfsr[95] & r_lfsr[42]) ^ (r_lfsr[60] & r_lfsr[79])
             ^ (r_nfsr[12] & r_nfsr[95] & r_lfsr[94]);
        yval = hval ^ r_lfsr[93] ^ r_nfsr[2] ^ r_nfsr[15] ^ r_nfsr[36] ^ r_nfsr[45]
             ^ r_nfsr[64] ^ r_nfsr[73] ^ r_nfsr[89];
        lout = r_lfsr[0];
        case (i_cmd.mode)
            MODE_INIT: begin
                lin = lfb ^ yval;
                nin = nfb ^ lout ^ yval;
            end
            MODE_KEYADD: begin
                lin = lfb ^ i_cmd.kbit;
                nin = nfb ^ lout;
            end
            default: begin
                lin = lfb;
                nin = nfb ^ lout;
            end
        endcase
        n_lfsr = r_lfsr;
        n_nfsr = r_nfsr;
        if (i_cmd.load) begin
            n_lfsr = {IV_PAD, i_iv};
            n_nfsr = i_key;
        end else if (i_cmd.step) begin
            n_lfsr = {lin, r_lfsr[127:1]};
            n_nfsr = {nin, r_nfsr[127:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= '0;
            r_nfsr <= '0;
        end else begin
            r_lfsr <= n_lfsr;
            r_nfsr <= n_nfsr;
        end
    end

    assign o_y = yval;

endmodule

### rtl/gr128_auth.sv
// Grain-128AEAD authentication unit: 64-bit tag accumulator and shift register.
// Depends on gr128_pkg.
module gr128_auth
    import gr128_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_auth_cmd   i_cmd,
    output logic [63:0] o_acc
);

    logic [63:0] r_acc, n_acc;
    logic [63:0] r_sr, n_sr;

    always_comb begin
        n_acc = r_acc;
        n_sr  = r_sr;
        if (i_cmd.clear) begin
            n_acc = '0;
            n_sr  = '0;
        end else begin
            if (i_cmd.acc_shift) begin
                n_acc = {i_cmd.bit_in, r_acc[63:1]};
            end else if (i_cmd.add || i_cmd.fold) begin
                n_acc = r_acc ^ r_sr;
            end
            if (i_cmd.sr_shift) begin
                n_sr = {i_cmd.bit_in, r_sr[63:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_sr  <= '0;
        end else begin
            r_acc <= n_acc;
            r_sr  <= n_sr;
        end
    end

    assign o_acc = r_acc;

endmodule

### rtl/grain128_aead_core.sv
// Grain-128AEAD core top level: configuration registers, sequencer, output register.
// Depends on gr128_pkg, gr128_cipher and gr128_auth.
//
//   channel   signals                             payload
//   input     i_valid / o_ready / i_data          t_in  {kind, data_in}
//   output    o_valid / i_ready / o_data          t_out {out_byte, last, tag_fail}
//   config    i_cfg_we / i_cfg_idx / i_cfg_data   64-bit write, no read-back
//
// Start loads key and nonce and runs the init and key-add phases; AD/encrypt/decrypt
// run the data phase; check compares one tag byte; finalize folds and emits the tag.
// Reset clears control, config, cipher and tag state, but not the payload registers.
// A finished result waits in the output register while the next transaction
// is accepted; the sequencer stalls only when it must load a busy output register.
module grain128_aead_core
    import gr128_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_INIT   = 7'b0000010,
        S_KEYADD = 7'b0000100,
        S_DATA   = 7'b0001000,
        S_FIN    = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_PUT    = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_cnt, n_cnt;
    logic [63:0] r_key_low, r_key_high, r_nonce_low;
    logic [31:0] r_nonce_high;
    logic [2:0]  r_kind, n_kind;
    logic [7:0]  r_din, n_din;
    logic [7:0]  r_res, n_res;
    logic        r_mbit, n_mbit;
    logic [2:0]  r_chk, n_chk;
    logic        r_flag, n_flag;
    logic        r_ovalid, n_ovalid;
    t_out        r_out, n_out;

    t_ciph_cmd   ciph_cmd;
    t_auth_cmd   auth_cmd;
    logic        y;
    logic [63:0] acc;
    logic        take;
    logic        slot_free;
    logic        dbit;

    gr128_cipher u_cipher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ciph_cmd),
        .i_key   ({r_key_high, r_key_low}),
        .i_iv    ({r_nonce_high, r_nonce_low}),
        .o_y     (y)
    );

    gr128_auth u_auth (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (auth_cmd),
        .o_acc   (acc)
    );

    assign o_ready   = (r_state == S_IDLE);
    assign take      = i_valid && o_ready;
    assign slot_free = !r_ovalid || i_ready;
    assign dbit      = r_din[r_cnt[3:1]];

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_kind   = r_kind;
        n_din    = r_din;
        n_res    = r_res;
        n_mbit   = r_mbit;
        n_chk    = r_chk;
        n_flag   = r_flag;
        n_ovalid = r_ovalid && !i_ready;
        n_out    = r_out;
        ciph_cmd = '{load: 1'b0, step: 1'b0, mode: MODE_RUN, kbit: 1'b0};
        auth_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    n_kind = i_data.kind;
                    n_din  = i_data.data_in;
                    n_res  = '0;
                    n_cnt  = '0;
                    case (i_data.kind)
                        KIND_START: begin
                            ciph_cmd.load  = 1'b1;
                            auth_cmd.clear = 1'b1;
                            n_chk   = '0;
                            n_flag  = 1'b0;
                            n_state = S_INIT;
                        end
                        KIND_AD, KIND_ENCRYPT, KIND_DECRYPT: begin
                            n_state = S_DATA;
                        end
                        KIND_FINALIZE: begin
                            n_chk   = '0;
                            n_flag  = 1'b0;
                            n_state = S_FIN;
                        end
                        KIND_CHECK: begin
                            if (acc[{r_chk, 3'b000} +: 8] != i_data.data_in) begin
                                n_flag = 1'b1;
                            end
                            n_chk   = r_chk + 3'd1;
                            n_state = S_PUT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INIT: begin
                ciph_cmd.step = 1'b1;
                ciph_cmd.mode = MODE_INIT;
                n_cnt = r_cnt + 8'd1;
                if (r_cnt == 8'd255) begin
                    n_state = S_KEYADD;
                end
            end
            S_KEYADD: begin
                ciph_cmd.step = 1'b1;
                ciph_cmd.mode = MODE_KEYADD;
                ciph_cmd.kbit = r_cnt[6] ? r_key_high[r_cnt[5:0]] : r_key_low[r_cnt[5:0]];
                auth_cmd.bit_in    = y;
                auth_cmd.acc_shift = !r_cnt[6];
                auth_cmd.sr_shift  = r_cnt[6];
                n_cnt = r_cnt + 8'd1;
                if (r_cnt == 8'd127) begin
                    n_state = S_PUT;
                end
            end
            S_DATA: begin
                ciph_cmd.step = 1'b1;
                if (!r_cnt[0]) begin
                    n_mbit = (r_kind == KIND_DECRYPT) ? (dbit ^ y) : dbit;
                    n_res  = {(r_kind != KIND_AD) && (dbit ^ y), r_res[7:1]};
                end else begin
                    auth_cmd.add      = r_mbit;
                    auth_cmd.sr_shift = 1'b1;
                    auth_cmd.bit_in   = y;
                end
                n_cnt = r_cnt + 8'd1;
                if (r_cnt[3:0] == 4'd15) begin
                    n_state = S_PUT;
                end
            end
            S_FIN: begin
                ciph_cmd.step = 1'b1;
                auth_cmd.fold = 1'b1;
                n_cnt   = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_out    = '{out_byte: acc[{r_cnt[2:0], 3'b000} +: 8],
                                 last: (r_cnt[2:0] == 3'd7), tag_fail: r_flag};
                    n_cnt    = r_cnt + 8'd1;
                    if (r_cnt[2:0] == 3'd7) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PUT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_out    = '{out_byte: r_res, last: 1'b1, tag_fail: r_flag};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_chk        <= '0;
            r_flag       <= 1'b0;
            r_ovalid     <= 1'b0;
            r_key_low    <= '0;
            r_key_high   <= '0;
            r_nonce_low  <= '0;
            r_nonce_high <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_chk    <= n_chk;
            r_flag   <= n_flag;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KEY_LOW:    r_key_low    <= i_cfg_data;
                    CFG_KEY_HIGH:   r_key_high   <= i_cfg_data;
                    CFG_NONCE_LOW:  r_nonce_low  <= i_cfg_data;
                    CFG_NONCE_HIGH: r_nonce_high <= i_cfg_data[31:0];
                    default:        r_key_low    <= r_key_low;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_din  <= n_din;
        r_res  <= n_res;
        r_mbit <= n_mbit;
        r_out  <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

endmodule

### tb/sv/tb.sv
// Self-checking bench for grain128_aead_core: a bit-level Grain-128AEAD predictor
// scores every output transaction in order against the block's results.
// Depends on gr128_pkg and the core RTL.
module tb;
    import gr128_pkg::*;

    class grain_byte_checker;
        bit [127:0] lfsr;
        bit [127:0] nfsr;
        bit [63:0]  acc;
        bit [63:0]  sreg;
        bit [2:0]   chk_pos;
        bit         tag_bad;
        bit [63:0]  key_lo;
        bit [63:0]  key_hi;
        bit [63:0]  iv_lo;
        bit [31:0]  iv_hi;
        t_out       pending_out[$];
        int         errors;

        function void set_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                CFG_KEY_LOW:    key_lo = val;
                CFG_KEY_HIGH:   key_hi = val;
                CFG_NONCE_LOW:  iv_lo = val;
                CFG_NONCE_HIGH: iv_hi = val[31:0];
                default: ;
            endcase
        endfunction

        function bit step_cipher(t_mode mode, bit kbit);
            bit lfb, nfb, hv, y, lout;
            lfb = lfsr[96] ^ lfsr[81] ^ lfsr[70] ^ lfsr[38] ^ lfsr[7] ^ lfsr[0];
            nfb = nfsr[96] ^ nfsr[91] ^ nfsr[56] ^ nfsr[26] ^ nfsr[0]
                ^ (nfsr[84] & nfsr[68]) ^ (nfsr[67] & nfsr[3]) ^ (nfsr[65] & nfsr[61])
                ^ (nfsr[59] & nfsr[27]) ^ (nfsr[48] & nfsr[40]) ^ (nfsr[18] & nfsr[17])
                ^ (nfsr[13] & nfsr[11]) ^ (nfsr[82] & nfsr[78] & nfsr[70])
                ^ (nfsr[25] & nfsr[24] & nfsr[22])
                ^ (nfsr[95] & nfsr[93] & nfsr[92] & nfsr[88]);
            hv = (nfsr[12] & lfsr[8]) ^ (lfsr[13] & lfsr[20]) ^ (nfsr[95] & lfsr[42])
               ^ (lfsr[60] & lfsr[79]) ^ (nfsr[12] & nfsr[95] & lfsr[94]);
            y = hv ^ lfsr[93] ^ nfsr[2] ^ nfsr[15] ^ nfsr[36] ^ nfsr[45]
              ^ nfsr[64] ^ nfsr[73] ^ nfsr[89];
            lout = lfsr[0];
            case (mode)
                MODE_INIT: begin
                    lfb ^= y;
                    nfb ^= y;
                end
                MODE_KEYADD: lfb ^= kbit;
                default: ;
            endcase
            lfsr = {lfb, lfsr[127:1]};
            nfsr = {nfb ^ lout, nfsr[127:1]};
            return y;
        endfunction

        function void mac_update(bit add, bit z);
            if (add)
                acc ^= sreg;
            sreg = {z, sreg[63:1]};
        endfunction

        function void load_and_init();
            int t;
            lfsr = {IV_PAD, iv_hi, iv_lo};
            nfsr = {key_hi, key_lo};
            acc = '0;
            sreg = '0;
            for (t = 0; t < 256; t++)
                void'(step_cipher(MODE_INIT, 1'b0));
            for (t = 0; t < 64; t++)
                acc[t] = step_cipher(MODE_KEYADD, key_lo[t]);
            for (t = 0; t < 64; t++)
                sreg[t] = step_cipher(MODE_KEYADD, key_hi[t]);
            chk_pos = '0;
            tag_bad = 1'b0;
        endfunction

        function void take_item(t_in item);
            t_out     r;
            bit [7:0] d;
            bit [7:0] res;
            bit       m;
            int       j;
            d = item.data_in;
            res = '0;
            case (item.kind)
                KIND_START: load_and_init();
                KIND_AD: begin
                    for (j = 0; j < 8; j++) begin
                        void'(step_cipher(MODE_RUN, 1'b0));
                        mac_update(d[j], step_cipher(MODE_RUN, 1'b0));
                    end
                end
                KIND_ENCRYPT: begin
                    for (j = 0; j < 8; j++) begin
                        res[j] = d[j] ^ step_cipher(MODE_RUN, 1'b0);
                        mac_update(d[j], step_cipher(MODE_RUN, 1'b0));
                    end
                end
                KIND_DECRYPT: begin
                    for (j = 0; j < 8; j++) begin
                        m = d[j] ^ step_cipher(MODE_RUN, 1'b0);
                        res[j] = m;
                        mac_update(m, step_cipher(MODE_RUN, 1'b0));
                    end
                end
                KIND_FINALIZE: begin
                    void'(step_cipher(MODE_RUN, 1'b0));
                    acc ^= sreg;
                    chk_pos = '0;
                    tag_bad = 1'b0;
                    for (j = 0; j < 8; j++) begin
                        r.out_byte = acc[8*j +: 8];
                        r.last = (j == 7);
                        r.tag_fail = 1'b0;
                        pending_out.push_back(r);
                    end
                    return;
                end
                KIND_CHECK: begin
                    if (acc[8*chk_pos +: 8] != d)
                        tag_bad = 1'b1;
                    chk_pos++;
                end
                default: return;
            endcase
            r.out_byte = res;
            r.last = 1'b1;
            r.tag_fail = tag_bad;
            pending_out.push_back(r);
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        function void check_out(t_out got);
            t_out want;
            if (pending_out.size() == 0) begin
                note_error($sformatf("unexpected output: byte %02h last %0b tag_fail %0b",
                                     got.out_byte, got.last, got.tag_fail));
                return;
            end
            want = pending_out.pop_front();
            if (got.out_byte !== want.out_byte || got.last !== want.last
                    || got.tag_fail !== want.tag_fail)
                note_error($sformatf(
                    "output mismatch: exp byte %02h last %0b tag_fail %0b, got %02h %0b %0b",
                    want.out_byte, want.last, want.tag_fail,
                    got.out_byte, got.last, got.tag_fail));
        endfunction

        function int pending();
            return pending_out.size();
        endfunction

        function bit [7:0] tag_byte(int k);
            return acc[8*(k % 8) +: 8];
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_data;
    logic        o_valid;
    logic        i_ready;
    t_out        o_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    grain128_aead_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    grain_byte_checker chk;
    int rx_hold_cycles = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int n_items = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #12_000_000;
        $display("** grain128_aead_core: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            chk.check_out(o_data);
    end

    initial begin : rx_drive
        int n;
        int served;
        served = 0;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else if (rx_quiet) begin
                n = 0;
            end else begin
                n = $urandom_range(0, 16);
            end
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            served++;
            if (served % 32 == 0)
                rx_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    task automatic send_item(input logic [2:0] kind, input logic [7:0] data);
        int  gap;
        t_in item;
        item.kind = kind;
        item.data_in = data;
        gap = tx_quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= item;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        chk.take_item(item);
        if (kind <= KIND_CHECK)
            n_items++;
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (chk.pending() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        chk.set_reg(idx, val);
    endtask

    task automatic reconfigure(input logic [63:0] k0, input logic [63:0] k1,
                               input logic [63:0] n0, input logic [31:0] n1);
        wait_results_done();
        repeat (400) @(posedge i_clk);
        write_reg(CFG_KEY_LOW, k0);
        write_reg(CFG_KEY_HIGH, k1);
        write_reg(CFG_NONCE_LOW, n0);
        write_reg(CFG_NONCE_HIGH, {32'h0, n1});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_packet();
        int       n_ad;
        int       n_msg;
        int       n_chk;
        int       k;
        bit [7:0] b;
        tx_quiet = ($urandom_range(0, 3) == 0);
        send_item(KIND_START, 8'($urandom));
        n_ad = $urandom_range(0, 4);
        send_item(KIND_AD, 8'(n_ad));
        repeat (n_ad) send_item(KIND_AD, 8'($urandom));
        n_msg = $urandom_range(0, 8);
        repeat (n_msg)
            send_item($urandom_range(0, 1) ? KIND_ENCRYPT : KIND_DECRYPT, 8'($urandom));
        if ($urandom_range(0, 9) == 0)
            wait_results_done();
        send_item(KIND_FINALIZE, 8'($urandom));
        n_chk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 10) : 8;
        for (k = 0; k < n_chk; k++) begin
            b = chk.tag_byte(k);
            if ($urandom_range(0, 7) == 0)
                b ^= 8'(1 << $urandom_range(0, 7));
            send_item(KIND_CHECK, b);
        end
    endtask

    initial begin : stimulus
        int ph;
        int k;
        chk = new();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // run on the zeroed registers before any start
        send_item(KIND_ENCRYPT, 8'h00);
        send_item(KIND_AD, 8'hFF);
        send_item(3'd6, 8'hFF);
        send_item(3'd7, 8'h00);
        send_item(KIND_CHECK, 8'h00);
        send_item(KIND_FINALIZE, 8'h00);
        send_item(KIND_FINALIZE, 8'hFF);

        reconfigure('1, '1, '1, '1);
        send_item(KIND_START, 8'hFF);
        send_item(KIND_AD, 8'h02);
        send_item(KIND_AD, 8'h00);
        send_item(KIND_AD, 8'hFF);
        send_item(KIND_ENCRYPT, 8'h00);
        send_item(KIND_ENCRYPT, 8'hFF);
        send_item(KIND_DECRYPT, 8'h00);
        send_item(KIND_DECRYPT, 8'hFF);
        send_item(KIND_FINALIZE, 8'h00);
        wait_results_done();
        for (k = 0; k < 8; k++)
            send_item(KIND_CHECK, chk.tag_byte(k));
        send_item(KIND_CHECK, ~chk.tag_byte(0));

        // stall the output while the bench keeps offering input with no gaps
        reconfigure('0, '0, '0, '0);
        n_items = 0;
        rx_hold_cycles = 1000;
        tx_quiet = 1'b1;
        send_item(KIND_START, 8'h00);
        repeat (24) send_item(KIND_ENCRYPT, 8'($urandom));
        send_item(KIND_FINALIZE, 8'h00);

        for (ph = 0; ph < 6; ph++) begin
            if (ph > 0)
                reconfigure(pick_word(), pick_word(), pick_word(), 32'(pick_word()));
            while (n_items < (ph + 1) * 78) begin
                if ($urandom_range(0, 9) == 0) begin
                    tx_quiet = 1'b0;
                    repeat ($urandom_range(1, 4))
                        send_item(3'($urandom_range(0, 7)), 8'($urandom));
                end else begin
                    send_packet();
                end
            end
        end

        wait_results_done();
        repeat (400) @(posedge i_clk);
        if (chk.errors == 0 && chk.pending() == 0)
            $display("** grain128_aead_core: PASSED **");
        else
            $display("** grain128_aead_core: FAILED **");
        $finish;
    end
endmodule
